>>> sv/iie_pkg.sv
// Shared types, opcodes and constants for the integer execute block.
package iie_pkg;

   localparam int NUM_REGS  = 32;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int XLEN      = 32;
   localparam int RID_W     = 5;

   localparam logic [XLEN-1:0] LUI_MASK  = 32'hffff_f000;
   localparam logic [XLEN-1:0] SHIFT_MAX = 32'd31;
   localparam logic [XLEN-1:0] PC_STEP   = 32'd4;

   // request tdata layout, lowest bit first
   localparam int REQ_DATA_W = 56;
   localparam int REQ_CMD_LO = 0;
   localparam int REQ_RD_LO  = 5;
   localparam int REQ_RSA_LO = 10;
   localparam int REQ_RSB_LO = 15;
   localparam int REQ_IMM_LO = 20;

   // response tdata layout, lowest bit first
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PC_LO  = 0;
   localparam int RSP_WEN    = 32;
   localparam int RSP_WIDX_LO = 33;
   localparam int RSP_WVAL_LO = 38;
   localparam int RSP_ILL    = 70;

   typedef enum logic [4:0] {
      OP_ADD   = 5'd0,
      OP_SUB   = 5'd1,
      OP_XOR   = 5'd2,
      OP_OR    = 5'd3,
      OP_AND   = 5'd4,
      OP_SLL   = 5'd5,
      OP_SRL   = 5'd6,
      OP_SRA   = 5'd7,
      OP_SLT   = 5'd8,
      OP_SLTU  = 5'd9,
      OP_ADDI  = 5'd10,
      OP_XORI  = 5'd11,
      OP_ORI   = 5'd12,
      OP_ANDI  = 5'd13,
      OP_SLTI  = 5'd14,
      OP_SLTIU = 5'd15,
      OP_LUI   = 5'd16,
      OP_BEQ   = 5'd17,
      OP_BNE   = 5'd18,
      OP_BLT   = 5'd19,
      OP_BLTU  = 5'd20,
      OP_BGE   = 5'd21,
      OP_BGEU  = 5'd22,
      OP_JAL   = 5'd23,
      OP_JALR  = 5'd24
   } op_type;

   typedef struct packed {
      logic            en;
      logic [RID_W-1:0] idx;
      logic [XLEN-1:0] value;
   } wr_port_type;

   // register numbers that hold state: not zero and inside the file
   function automatic logic reg_in_range(input logic [RID_W-1:0] idx);
      return (idx != '0) && ({1'b0, idx} < (RID_W + 1)'(NUM_REGS));
   endfunction

endpackage

>>> sv/iie_regfile.sv
// Register file: two registered read ports, one write port, valid bits and write bypass.
module iie_regfile
   import iie_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [RID_W-1:0] rd_addr_a,
   input  logic [RID_W-1:0] rd_addr_b,
   input  wr_port_type      wr,
   output logic [XLEN-1:0]  rd_data_a,
   output logic [XLEN-1:0]  rd_data_b
);

   logic [XLEN-1:0]     mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [XLEN-1:0]     q_a_ff, q_b_ff;
   logic [XLEN-1:0]     byp_val_ff;
   logic                byp_a_ff, byp_b_ff;
   logic                live_a_ff, live_b_ff;

   logic [REG_IDX_W-1:0] ra, rb, wa;

   assign ra = rd_addr_a[REG_IDX_W-1:0];
   assign rb = rd_addr_b[REG_IDX_W-1:0];
   assign wa = wr.idx[REG_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wa] <= wr.value;
      end
      if (rd_en) begin
         q_a_ff <= mem[ra];
         q_b_ff <= mem[rb];
      end
   end

   // entries not yet written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wa] <= 1'b1;
      end
   end

   // the write landing this cycle is not yet in the array: take it directly
   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_val_ff <= wr.value;
         byp_a_ff   <= wr.en && (wr.idx == rd_addr_a);
         byp_b_ff   <= wr.en && (wr.idx == rd_addr_b);
         live_a_ff  <= reg_in_range(rd_addr_a) && valid_ff[ra];
         live_b_ff  <= reg_in_range(rd_addr_b) && valid_ff[rb];
      end
   end

   assign rd_data_a = byp_a_ff ? byp_val_ff : (live_a_ff ? q_a_ff : '0);
   assign rd_data_b = byp_b_ff ? byp_val_ff : (live_b_ff ? q_b_ff : '0);

endmodule

>>> sv/iie_exec.sv
// Execute logic: ALU, compares, branch and jump target, writeback selection.
module iie_exec
   import iie_pkg::*;
(
   input  logic [4:0]       cmd,
   input  logic [RID_W-1:0] dest_reg,
   input  logic [XLEN-1:0]  immediate,
   input  logic [XLEN-1:0]  src_a,
   input  logic [XLEN-1:0]  src_b,
   input  logic [XLEN-1:0]  pc,
   output logic [XLEN-1:0]  next_pc,
   output wr_port_type      wr,
   output logic             illegal
);

   op_type          op;
   logic [XLEN-1:0] seq_pc, val, target;
   logic [4:0]      shamt;
   logic            writes, taken, slt_ab, slt_ai, ult_ab, ult_ai;

   assign op     = op_type'(cmd);
   assign seq_pc = pc + PC_STEP;
   assign shamt  = src_b[4:0];
   assign slt_ab = $signed(src_a) < $signed(src_b);
   assign slt_ai = $signed(src_a) < $signed(immediate);
   assign ult_ab = src_a < src_b;
   assign ult_ai = src_a < immediate;
   assign target = pc + {immediate[XLEN-2:0], 1'b0};

   always_comb begin
      val     = '0;
      writes  = 1'b0;
      taken   = 1'b0;
      illegal = 1'b0;
      next_pc = seq_pc;
      unique case (op)
         OP_ADD:   begin val = src_a + src_b;     writes = 1'b1; end
         OP_SUB:   begin val = src_a - src_b;     writes = 1'b1; end
         OP_XOR:   begin val = src_a ^ src_b;     writes = 1'b1; end
         OP_OR:    begin val = src_a | src_b;     writes = 1'b1; end
         OP_AND:   begin val = src_a & src_b;     writes = 1'b1; end
         OP_SLL, OP_SRL, OP_SRA: begin
            if (src_b > SHIFT_MAX) begin
               illegal = 1'b1;
            end else begin
               writes = 1'b1;
               case (op)
                  OP_SLL:  val = src_a << shamt;
                  OP_SRL:  val = src_a >> shamt;
                  default: val = XLEN'($signed(src_a) >>> shamt);
               endcase
            end
         end
         OP_SLT:   begin val = XLEN'(slt_ab);     writes = 1'b1; end
         OP_SLTU:  begin val = XLEN'(ult_ab);     writes = 1'b1; end
         OP_ADDI:  begin val = src_a + immediate; writes = 1'b1; end
         OP_XORI:  begin val = src_a ^ immediate; writes = 1'b1; end
         OP_ORI:   begin val = src_a | immediate; writes = 1'b1; end
         OP_ANDI:  begin val = src_a & immediate; writes = 1'b1; end
         OP_SLTI:  begin val = XLEN'(slt_ai);     writes = 1'b1; end
         OP_SLTIU: begin val = XLEN'(ult_ai);     writes = 1'b1; end
         OP_LUI:   begin val = immediate & LUI_MASK; writes = 1'b1; end
         OP_BEQ:   taken = (src_a == src_b);
         OP_BNE:   taken = (src_a != src_b);
         OP_BLT:   taken = slt_ab;
         OP_BLTU:  taken = ult_ab;
         OP_BGE:   taken = !slt_ab;
         OP_BGEU:  taken = !ult_ab;
         OP_JAL:   begin val = seq_pc; writes = 1'b1; taken = 1'b1; end
         OP_JALR: begin
            val     = seq_pc;
            writes  = 1'b1;
            next_pc = (src_a + immediate) & ~XLEN'(1);
         end
         default: ;
      endcase
      if (taken) begin
         next_pc = target;
      end
      // an oversized shift leaves the pc where it is
      if (illegal) begin
         next_pc = pc;
      end
   end

   always_comb begin
      wr.en    = writes && reg_in_range(dest_reg);
      wr.idx   = wr.en ? dest_reg : '0;
      wr.value = wr.en ? val : '0;
   end

endmodule

>>> sv/integer_instruction_execute.sv
// Top level: instruction register, execute stage, pc and response register.
//
//  channel | ports                    | item
//  --------+--------------------------+---------------------------------------
//  req     | req_tvalid/tready/tdata  | decoded instruction, one per item
//  rsp     | rsp_tvalid/tready/tdata  | next pc, register write, illegal flag
//
//  One item per cycle unless rsp stalls; staged in instruction then response register.
//  Register read is a registered read of the file in the accept cycle; the
//  execute stage's write is bypassed into the read so back-to-back items chain.
//  Reset clears pc, the register valid bits and both stage valids.
//  A stalled response holds the execute stage, which then stops req_tready.
module integer_instruction_execute
   import iie_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cmd[4:0], dest_reg[9:5], src_reg_a[14:10], src_reg_b[19:15], immediate[51:20]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // next_pc[31:0], reg_written[32], written_index[37:33], written_value[69:38],
   // illegal[70]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                  s1_valid_ff;
   logic [4:0]            s1_cmd_ff;
   logic [RID_W-1:0]      s1_dest_ff;
   logic [XLEN-1:0]       s1_imm_ff;
   logic [XLEN-1:0]       pc_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic            req_fire, s1_fire;
   logic [XLEN-1:0] src_a, src_b, exe_pc;
   logic            exe_illegal;
   wr_port_type     exe_wr, rf_wr;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= req_tdata[REQ_CMD_LO +: 5];
         s1_dest_ff <= req_tdata[REQ_RD_LO +: RID_W];
         s1_imm_ff  <= req_tdata[REQ_IMM_LO +: XLEN];
      end
   end

   // commit writes only when the item moves into the response register
   always_comb begin
      rf_wr    = exe_wr;
      rf_wr.en = exe_wr.en && s1_fire;
   end

   iie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr_a (req_tdata[REQ_RSA_LO +: RID_W]),
      .rd_addr_b (req_tdata[REQ_RSB_LO +: RID_W]),
      .wr        (rf_wr),
      .rd_data_a (src_a),
      .rd_data_b (src_b)
   );

   iie_exec u_exec (
      .cmd       (s1_cmd_ff),
      .dest_reg  (s1_dest_ff),
      .immediate (s1_imm_ff),
      .src_a     (src_a),
      .src_b     (src_b),
      .pc        (pc_ff),
      .next_pc   (exe_pc),
      .wr        (exe_wr),
      .illegal   (exe_illegal)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (s1_fire) begin
         pc_ff <= exe_pc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= {1'b0, exe_illegal, exe_wr.value, exe_wr.idx, exe_wr.en, exe_pc};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/iie_checker.sv
// Port-level checker for the integer execute block, bound to the top level.
module iie_checker
   import iie_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic            wen, ill;
   logic [RID_W-1:0] widx;
   logic [XLEN-1:0] wval;

   assign wen  = rsp_tdata[RSP_WEN];
   assign ill  = rsp_tdata[RSP_ILL];
   assign widx = rsp_tdata[RSP_WIDX_LO +: RID_W];
   assign wval = rsp_tdata[RSP_WVAL_LO +: XLEN];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid straight after reset");

   a_illegal_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ill |-> !wen)
      else $error("illegal item reported a register write");

   a_write_not_r0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && wen |-> widx != '0)
      else $error("write reported to register zero");

   a_no_write_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !wen |-> widx == '0 && wval == '0)
      else $error("write fields not cleared without a write");

endmodule

bind integer_instruction_execute iie_checker u_iie_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
